@@ hdl/okla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package okla_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_READOUT = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_READ      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [KEY_W-1:0]  key;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  key_out;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;
  } out_t;

endpackage

`default_nettype wire

@@ hdl/okla_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Key memory: one write port, one read port with registered data.
module okla_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [okla_pkg::KEY_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [okla_pkg::KEY_W-1:0]  rd_data
);

  logic [okla_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ordered_key_list_append_delete.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit keys held in a single-read-port
// memory and walked by a small sequencer with one shared key comparator. An
// append writes the key after the last held key. A remove scans for the key
// and closes up later keys, sharing one memory read per cycle between the
// two. A readout gives one result per cycle while the result register can
// take it; a full list or an empty list answers from the FIN state. Results
// wait in FIN or READ while out_ready is low. in_ready is high only between
// items; the result register holds an item's last result as the next comes in.
module ordered_key_list_append_delete #(
  parameter int CAPACITY = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire okla_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output okla_pkg::out_t      out_data
);

  localparam int CW = okla_pkg::CNT_W;
  localparam int PW = okla_pkg::POS_W;
  localparam int KW = okla_pkg::KEY_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  okla_pkg::state_t  state_r, state_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  okla_pkg::status_t fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  okla_pkg::out_t    out_r, out_nxt;

  logic              in_fire;
  logic              can_load;
  logic              out_load;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic              more;
  logic              hit;
  logic              is_full;
  logic              is_empty;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [KW-1:0]     wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [KW-1:0]     rd_data;

  okla_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == okla_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign more      = (idx_inc < cnt_r);
  assign hit       = (rd_data == key_r);   // the shared comparator
  assign is_full   = (cnt_r == CAP_CNT);
  assign is_empty  = (cnt_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      okla_pkg::S_IDLE: begin
        if (in_fire) begin
          priority if (in_data.action == okla_pkg::ACT_APPEND) begin
            state_nxt = okla_pkg::S_FIN;
          end else if (in_data.action == okla_pkg::ACT_REMOVE) begin
            state_nxt = is_empty ? okla_pkg::S_FIN : okla_pkg::S_SCAN;
          end else if (in_data.action == okla_pkg::ACT_READOUT) begin
            state_nxt = is_empty ? okla_pkg::S_FIN : okla_pkg::S_READ;
          end else begin
            state_nxt = okla_pkg::S_IDLE;
          end
        end
      end
      okla_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = more ? okla_pkg::S_SHIFT : okla_pkg::S_FIN;
        end else if (!more) begin
          state_nxt = okla_pkg::S_FIN;
        end
      end
      okla_pkg::S_SHIFT: begin
        if (!more) begin
          state_nxt = okla_pkg::S_FIN;
        end
      end
      okla_pkg::S_READ: begin
        if (can_load && !more) begin
          state_nxt = okla_pkg::S_IDLE;
        end
      end
      okla_pkg::S_FIN: begin
        if (can_load) begin
          state_nxt = okla_pkg::S_IDLE;
        end
      end
      default: state_nxt = okla_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    key_nxt  = key_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    fin_nxt  = fin_r;
    out_load = 1'b0;
    out_nxt  = out_r;
    wr_en    = 1'b0;
    wr_addr  = cnt_r[AW-1:0];
    wr_data  = key_r;
    rd_en    = 1'b0;
    rd_addr  = idx_inc[AW-1:0];

    unique case (state_r)
      okla_pkg::S_IDLE: begin
        if (in_fire) begin
          key_nxt = in_data.key;
          idx_nxt = '0;
          pos_nxt = '0;
          rd_addr = '0;
          priority if (in_data.action == okla_pkg::ACT_APPEND) begin
            if (is_full) begin
              fin_nxt = okla_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_data = in_data.key;
              pos_nxt = cnt_r[PW-1:0];
              cnt_nxt = cnt_r + 1'b1;
              fin_nxt = okla_pkg::ST_APPENDED;
            end
          end else if (in_data.action == okla_pkg::ACT_REMOVE) begin
            fin_nxt = okla_pkg::ST_NOT_FOUND;
            rd_en   = !is_empty;
          end else if (in_data.action == okla_pkg::ACT_READOUT) begin
            fin_nxt = okla_pkg::ST_EMPTY;
            rd_en   = !is_empty;
          end else begin
            fin_nxt = fin_r;
          end
        end
      end
      okla_pkg::S_SCAN: begin
        if (hit) begin
          pos_nxt = idx_r[PW-1:0];
          fin_nxt = okla_pkg::ST_REMOVED;
        end
        if (more) begin
          rd_en   = 1'b1;
          idx_nxt = idx_inc;
        end else if (hit) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      okla_pkg::S_SHIFT: begin
        // move entry idx down one place while fetching the next
        wr_en   = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        wr_data = rd_data;
        if (more) begin
          rd_en   = 1'b1;
          idx_nxt = idx_inc;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      okla_pkg::S_READ: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_nxt.status      = okla_pkg::ST_READ;
          out_nxt.key_out     = rd_data;
          out_nxt.position    = idx_r[PW-1:0];
          out_nxt.entry_count = cnt_r;
          out_nxt.last        = !more;
          if (more) begin
            rd_en   = 1'b1;
            idx_nxt = idx_inc;
          end
        end
      end
      okla_pkg::S_FIN: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_nxt.status      = fin_r;
          out_nxt.key_out     = key_r;
          out_nxt.position    = pos_r;
          out_nxt.entry_count = cnt_r;
          out_nxt.last        = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okla_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    fin_r <= fin_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("held count above capacity");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.action != okla_pkg::ACT_UNUSED)) |=> !in_ready)
    else $error("ready again straight after a real item");

  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == okla_pkg::ST_READ && out_data.last)
      |-> ((CW'(out_data.position) + 1'b1) == out_data.entry_count))
    else $error("readout last marker not on final entry");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= CAP_CNT))
    else $error("reported count above capacity");
`endif

endmodule

`default_nettype wire
